FILE: src/bdgd_pkg.sv
package bdgd_pkg;

    // gesture codes carried on the result stream
    typedef enum logic [2:0] {
        G_NONE      = 3'd0,
        G_SW3_LONG  = 3'd1,
        G_SW3_SHORT = 3'd2,
        G_CLICK1    = 3'd3,
        G_CLICK2    = 3'd4,
        G_CLICK3    = 3'd5,
        G_SW1_SHORT = 3'd6
    } t_gesture;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SCAN_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_DEBOUNCE    = 2'd1;
    localparam t_cfg_idx CFG_LONG_PRESS  = 2'd2;

    // configuration field widths and reset values
    localparam int SCAN_W   = 16;
    localparam int DEB_W    = 8;
    localparam int LONG_W   = 32;
    localparam int CFG_D_W  = 32;
    localparam int CLICK_W  = 8;

    localparam logic [SCAN_W-1:0] SCAN_RST = 16'd10;
    localparam logic [DEB_W-1:0]  DEB_RST  = 8'd3;
    localparam logic [LONG_W-1:0] LONG_RST = 32'd5000;

endpackage

FILE: src/button_debounce_gesture_decoder.sv
// Two-button debouncer and gesture decoder. Each input transaction is one
// timer tick carrying read_ok, the SW3 level (1 = pressed) and the SW1 level
// (0 = pressed). Every scan_period ticks both buttons are sampled through
// integrating debounce counters, and every tick yields exactly one result
// transaction with a gesture code (none, SW3 long, SW3 short, one, two or
// three SW1 clicks during an SW3 hold, or a lone SW1 press). The block takes
// one tick per clock cycle unless the result stream stalls: the whole state update
// and decode is done in the cycle a tick is accepted and the gesture lands in the
// output register, so the result is valid in the next cycle. The output register
// lets a new tick in whenever it is empty or being drained in the same cycle.
// Configuration writes are always accepted and take effect from the next tick on.
module button_debounce_gesture_decoder #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [0] read_ok, [1] sw3_level,
                                                            // [2] sw1_level, rest zero
    // gesture stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [2:0] gesture, rest zero
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bdgd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bdgd_pkg::CFG_D_W-1:0]     i_cfg_data
);
    import bdgd_pkg::*;

    localparam int TW    = TIME_WIDTH;
    localparam int CMP_W = (TIME_WIDTH > LONG_W) ? TIME_WIDTH : LONG_W;

    // configuration registers
    logic [SCAN_W-1:0]  r_scan_period;
    logic [DEB_W-1:0]   r_debounce_count;
    logic [LONG_W-1:0]  r_long_press;

    // tick state
    logic [TW-1:0]      r_tick, n_tick;
    logic [TW-1:0]      r_last_scan, n_last_scan;
    logic [DEB_W-1:0]   r_sw3_deb, n_sw3_deb;
    logic               r_sw3_down, n_sw3_down;
    logic               r_sw3_armed, n_sw3_armed;
    logic               r_sw3_rel, n_sw3_rel;
    logic [TW-1:0]      r_sw3_stamp, n_sw3_stamp;
    logic [TW-1:0]      r_sw3_hold, n_sw3_hold;
    logic [DEB_W-1:0]   r_sw1_deb, n_sw1_deb;
    logic               r_sw1_down, n_sw1_down;
    logic               r_sw1_rel, n_sw1_rel;
    logic [CLICK_W-1:0] r_clicks, n_clicks;

    // output register
    logic               r_out_valid;
    t_gesture           r_gesture, n_gesture;

    logic               in_xact;
    logic               rd_ok, sw3_pressed, sw1_pressed;
    logic               scan;
    logic [TW-1:0]      since_scan, held_now;

    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_gesture};
    assign o_cfg_ready   = 1'b1;

    assign rd_ok       = s_axis_tdata[0];
    assign sw3_pressed = s_axis_tdata[1];
    assign sw1_pressed = !s_axis_tdata[2];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period    <= SCAN_RST;
            r_debounce_count <= DEB_RST;
            r_long_press     <= LONG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCAN_PERIOD: r_scan_period    <= i_cfg_data[SCAN_W-1:0];
                CFG_DEBOUNCE:    r_debounce_count <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS:  r_long_press     <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // per-tick update: time, scan, debounce, decode
    always_comb begin
        n_tick      = r_tick + TW'(1);
        n_last_scan = r_last_scan;
        n_sw3_deb   = r_sw3_deb;
        n_sw3_down  = r_sw3_down;
        n_sw3_armed = r_sw3_armed;
        n_sw3_rel   = r_sw3_rel;
        n_sw3_stamp = r_sw3_stamp;
        n_sw3_hold  = r_sw3_hold;
        n_sw1_deb   = r_sw1_deb;
        n_sw1_down  = r_sw1_down;
        n_sw1_rel   = r_sw1_rel;
        n_clicks    = r_clicks;
        n_gesture   = G_NONE;

        // scan timer
        since_scan = n_tick - r_last_scan;
        scan       = CMP_W'(since_scan) >= CMP_W'(r_scan_period);
        if (scan) begin
            n_last_scan = r_last_scan + TW'(r_scan_period);
        end

        if (scan && rd_ok) begin
            // sw3 integrating debounce
            if (sw3_pressed) begin
                if (r_sw3_deb < r_debounce_count) begin
                    n_sw3_deb = r_sw3_deb + DEB_W'(1);
                    if (n_sw3_deb == r_debounce_count && !r_sw3_down) begin
                        n_sw3_down  = 1'b1;
                        n_sw3_armed = 1'b1;
                        n_sw3_stamp = n_tick;
                    end
                end
            end else if (r_sw3_deb != '0) begin
                n_sw3_deb = r_sw3_deb - DEB_W'(1);
                if (n_sw3_deb == '0 && r_sw3_down) begin
                    n_sw3_down = 1'b0;
                    n_sw3_rel  = 1'b1;
                    n_sw3_hold = n_tick - r_sw3_stamp;
                end
            end

            // sw1 integrating debounce and click counting
            if (sw1_pressed) begin
                if (r_sw1_deb < r_debounce_count) begin
                    n_sw1_deb = r_sw1_deb + DEB_W'(1);
                    if (n_sw1_deb == r_debounce_count && !r_sw1_down) begin
                        n_sw1_down = 1'b1;
                        if (r_clicks != '1) begin
                            n_clicks = r_clicks + CLICK_W'(1);
                        end
                    end
                end
            end else if (r_sw1_deb != '0) begin
                n_sw1_deb = r_sw1_deb - DEB_W'(1);
                if (n_sw1_deb == '0 && r_sw1_down) begin
                    n_sw1_down = 1'b0;
                    n_sw1_rel  = 1'b1;
                end
            end
        end

        // gesture decode, long hold first
        held_now = n_tick - n_sw3_stamp;
        if (n_sw3_down && n_sw3_armed && n_clicks == '0 &&
            CMP_W'(held_now) >= CMP_W'(r_long_press)) begin
            n_sw3_armed = 1'b0;
            n_gesture   = G_SW3_LONG;
        end else begin
            if (n_sw3_rel) begin
                n_sw3_rel = 1'b0;
                if (CMP_W'(n_sw3_hold) < CMP_W'(r_long_press)) begin
                    unique case (n_clicks)
                        CLICK_W'(0): n_gesture = G_SW3_SHORT;
                        CLICK_W'(1): n_gesture = G_CLICK1;
                        CLICK_W'(2): n_gesture = G_CLICK2;
                        CLICK_W'(3): n_gesture = G_CLICK3;
                        default:     n_gesture = G_NONE;
                    endcase
                    n_clicks = '0;
                end
            end
            if (n_sw1_rel) begin
                n_sw1_rel = 1'b0;
                if (!n_sw3_down) begin
                    n_clicks  = '0;
                    n_gesture = G_SW1_SHORT;
                end
            end
        end
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_last_scan <= '0;
            r_sw3_deb   <= '0;
            r_sw3_down  <= 1'b0;
            r_sw3_armed <= 1'b0;
            r_sw3_rel   <= 1'b0;
            r_sw3_stamp <= '0;
            r_sw3_hold  <= '0;
            r_sw1_deb   <= '0;
            r_sw1_down  <= 1'b0;
            r_sw1_rel   <= 1'b0;
            r_clicks    <= '0;
        end else if (in_xact) begin
            r_tick      <= n_tick;
            r_last_scan <= n_last_scan;
            r_sw3_deb   <= n_sw3_deb;
            r_sw3_down  <= n_sw3_down;
            r_sw3_armed <= n_sw3_armed;
            r_sw3_rel   <= n_sw3_rel;
            r_sw3_stamp <= n_sw3_stamp;
            r_sw3_hold  <= n_sw3_hold;
            r_sw1_deb   <= n_sw1_deb;
            r_sw1_down  <= n_sw1_down;
            r_sw1_rel   <= n_sw1_rel;
            r_clicks    <= n_clicks;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xact) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_gesture <= n_gesture;
        end
    end

    // a debounced-down button always has a nonzero integrator
    a_sw3_down_deb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw3_down |-> (r_sw3_deb != '0))
        else $error("sw3 down with empty debounce counter");

    a_sw1_down_deb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw1_down |-> (r_sw1_deb != '0))
        else $error("sw1 down with empty debounce counter");

    // every accepted tick leaves a result waiting
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdgd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_TICKS = 200;
    localparam int QUIET_TICKS = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    logic [CFG_D_W-1:0] i_cfg_data;

    button_debounce_gesture_decoder #(
        .TIME_WIDTH(32)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow copy of the decoder registers
    logic [SCAN_W-1:0] cfg_scan = SCAN_RST;
    logic [DEB_W-1:0]  cfg_deb  = DEB_RST;
    logic [LONG_W-1:0] cfg_long = LONG_RST;

    // shadow copy of the decoder state
    logic [31:0]        now_t     = '0;
    logic [31:0]        scan_t    = '0;
    logic [DEB_W-1:0]   sw3_cnt   = '0;
    logic               sw3_dn    = 1'b0;
    logic               sw3_armed = 1'b0;
    logic               sw3_rel   = 1'b0;
    logic [31:0]        press_t   = '0;
    logic [31:0]        hold_len  = '0;
    logic [DEB_W-1:0]   sw1_cnt   = '0;
    logic               sw1_dn    = 1'b0;
    logic               sw1_rel   = 1'b0;
    logic [CLICK_W-1:0] clicks    = '0;

    t_gesture gesture_q[$];

    int  ticks_sent  = 0;
    int  n_results   = 0;
    int  n_fail      = 0;
    int  n_reported  = 0;
    int  cycles      = 0;
    int  miss_pct    = 0;
    int  quiet_from  = 0;
    bit  idle_en     = 1'b1;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // advance the shadow state by one tick and return the gesture it yields
    function automatic t_gesture decode_tick(bit ok, bit sw3_lvl, bit sw1_lvl);
        t_gesture g;
        bit       sw1_pressed;
        sw1_pressed = !sw1_lvl;
        now_t = now_t + 32'd1;
        if (now_t - scan_t >= {16'd0, cfg_scan}) begin
            scan_t = scan_t + {16'd0, cfg_scan};
            if (ok) begin
                // sw3 integrator, active high
                if (sw3_lvl) begin
                    if (sw3_cnt < cfg_deb) begin
                        sw3_cnt = sw3_cnt + 8'd1;
                        if (sw3_cnt == cfg_deb && !sw3_dn) begin
                            sw3_dn    = 1'b1;
                            sw3_armed = 1'b1;
                            press_t   = now_t;
                        end
                    end
                end else if (sw3_cnt > 0) begin
                    sw3_cnt = sw3_cnt - 8'd1;
                    if (sw3_cnt == 0 && sw3_dn) begin
                        sw3_dn   = 1'b0;
                        sw3_rel  = 1'b1;
                        hold_len = now_t - press_t;
                    end
                end
                // sw1 integrator, active low pin
                if (sw1_pressed) begin
                    if (sw1_cnt < cfg_deb) begin
                        sw1_cnt = sw1_cnt + 8'd1;
                        if (sw1_cnt == cfg_deb && !sw1_dn) begin
                            sw1_dn = 1'b1;
                            if (clicks != 8'hFF)
                                clicks = clicks + 8'd1;
                        end
                    end
                end else if (sw1_cnt > 0) begin
                    sw1_cnt = sw1_cnt - 8'd1;
                    if (sw1_cnt == 0 && sw1_dn) begin
                        sw1_dn  = 1'b0;
                        sw1_rel = 1'b1;
                    end
                end
            end
        end

        // long hold wins the tick outright
        if (sw3_dn && sw3_armed && clicks == 0 && (now_t - press_t) >= cfg_long) begin
            sw3_armed = 1'b0;
            return G_SW3_LONG;
        end
        g = G_NONE;
        if (sw3_rel) begin
            sw3_rel = 1'b0;
            if (hold_len < cfg_long) begin
                case (clicks)
                    8'd0: g = G_SW3_SHORT;
                    8'd1: g = G_CLICK1;
                    8'd2: g = G_CLICK2;
                    8'd3: g = G_CLICK3;
                    default: g = G_NONE;
                endcase
                clicks = '0;
            end
        end
        if (sw1_rel) begin
            sw1_rel = 1'b0;
            if (!sw3_dn) begin
                clicks = '0;
                g      = G_SW1_SHORT;
            end
        end
        return g;
    endfunction

    // ticks needed for the debouncer to settle, sometimes cut short
    function automatic int settle_len();
        int per;
        per = (cfg_scan == 0) ? 1 : int'(cfg_scan);
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(1, int'(cfg_deb) * per + 1);
        return int'(cfg_deb) * per + $urandom_range(1, 2 * per);
    endfunction

    // send one tick transaction; valid stays high for the next call
    task automatic send_tick(bit ok, bit sw3_lvl, bit sw1_lvl);
        // no idling on either side in the closing stretch
        if (quiet_from > 0 && ticks_sent >= quiet_from)
            idle_en = 1'b0;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, sw1_lvl, sw3_lvl, ok};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gesture_q.push_back(decode_tick(ok, sw3_lvl, sw1_lvl));
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_levels(bit sw3_lvl, bit sw1_lvl, int n);
        for (int i = 0; i < n; i++)
            send_tick($urandom_range(0, 99) >= miss_pct, sw3_lvl, sw1_lvl);
    endtask

    // stop sending and let every pending gesture come out
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (gesture_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_D_W-1:0] val);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SCAN_PERIOD: cfg_scan = val[SCAN_W-1:0];
            CFG_DEBOUNCE:    cfg_deb  = val[DEB_W-1:0];
            CFG_LONG_PRESS:  cfg_long = val[LONG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(int scan, int deb, logic [31:0] long_t);
        write_reg(CFG_SCAN_PERIOD, scan);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, long_t);
    endtask

    // lone sw1 press with the reset settings
    task automatic test_reset_defaults();
        hold_levels(0, 1, 5);
        hold_levels(0, 0, 35);
        hold_levels(0, 1, 35);
    endtask

    // every gesture code with fast scanning
    task automatic test_gestures();
        set_config(0, 1, 6);
        hold_levels(1, 1, 3);
        hold_levels(0, 1, 2);
        for (int k = 1; k <= 4; k++) begin
            hold_levels(1, 1, 1);
            repeat (k) begin
                hold_levels(1, 0, 1);
                hold_levels(1, 1, 1);
            end
            hold_levels(0, 1, 2);
        end
        // long hold, then its release gives nothing
        hold_levels(1, 1, 10);
        hold_levels(0, 1, 2);
        hold_levels(0, 0, 2);
        hold_levels(0, 1, 2);
        // both released together: sw1 overrides
        hold_levels(1, 1, 1);
        hold_levels(1, 0, 2);
        hold_levels(0, 1, 2);
        // long hold after a click keeps the count until a lone sw1
        hold_levels(1, 1, 1);
        hold_levels(1, 0, 1);
        hold_levels(1, 1, 10);
        hold_levels(0, 1, 2);
        hold_levels(0, 0, 1);
        hold_levels(0, 1, 2);
        // invalid reads leave the debouncers alone
        miss_pct = 100;
        hold_levels(1, 0, 5);
        miss_pct = 0;
        hold_levels(0, 1, 3);
        // zero long threshold fires on the press tick
        write_reg(CFG_LONG_PRESS, 0);
        hold_levels(1, 1, 2);
        hold_levels(0, 1, 2);
    endtask

    task automatic test_debounce_edges();
        set_config(0, 0, 6);
        hold_levels(1, 0, 4);
        hold_levels(0, 1, 4);
        // press accepted, then threshold dropped to zero before release
        write_reg(CFG_DEBOUNCE, 2);
        hold_levels(1, 0, 3);
        write_reg(CFG_DEBOUNCE, 0);
        hold_levels(0, 1, 3);
        // threshold lowered under a running counter
        write_reg(CFG_DEBOUNCE, 4);
        hold_levels(1, 0, 2);
        write_reg(CFG_DEBOUNCE, 1);
        hold_levels(1, 0, 3);
        hold_levels(0, 1, 3);
    endtask

    task automatic test_scan_extremes();
        set_config(16'hFFFF, 1, 6);
        hold_levels(1, 0, 6);
        write_reg(CFG_SCAN_PERIOD, 1);
        hold_levels(0, 1, 4);
        set_config(3, 2, 40);
        hold_levels(0, 0, 12);
        hold_levels(0, 1, 12);
    endtask

    task automatic test_debounce_max();
        set_config(0, 255, 32'hFFFF_FFFF);
        hold_levels(1, 1, 258);
        hold_levels(0, 1, 258);
    endtask

    task automatic test_click_overflow();
        set_config(0, 1, 32'hFFFF_FFFF);
        hold_levels(1, 1, 1);
        repeat (260) begin
            hold_levels(1, 0, 1);
            hold_levels(1, 1, 1);
        end
        hold_levels(0, 1, 2);
        hold_levels(0, 0, 1);
        hold_levels(0, 1, 2);
    endtask

    task automatic test_random();
        int goal;
        int phase;
        int k;
        int n;
        logic [31:0] long_t;
        goal       = ticks_sent + RANDOM_TICKS;
        quiet_from = goal - QUIET_TICKS;
        phase      = 0;
        while (ticks_sent < goal) begin
            case ($urandom_range(0, 9))
                0:       long_t = 32'hFFFF_FFFF;
                1:       long_t = $urandom_range(0, 1);
                default: long_t = $urandom_range(3, 80);
            endcase
            set_config($urandom_range(0, 3) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 3),
                       $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 4), long_t);
            miss_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
            repeat (6) begin
                case ($urandom_range(0, 9))
                    // sw3 hold with clicks, sometimes released together
                    0, 1, 2: begin
                        k = $urandom_range(0, 5);
                        hold_levels(1, 1, settle_len());
                        for (int i = 0; i < k; i++) begin
                            hold_levels(1, 0, settle_len());
                            if (i < k - 1 || $urandom_range(0, 3) != 0)
                                hold_levels(1, 1, settle_len());
                        end
                        hold_levels(0, 1, settle_len());
                    end
                    // lone sw1 press
                    3, 4: begin
                        hold_levels(0, 0, settle_len());
                        hold_levels(0, 1, settle_len());
                    end
                    // sw3 long hold
                    5: begin
                        n = settle_len() + 2;
                        if (cfg_long <= 150)
                            n += int'(cfg_long);
                        hold_levels(1, 1, n);
                        hold_levels(0, 1, settle_len());
                    end
                    // bouncing pins
                    6, 7: begin
                        repeat ($urandom_range(5, 30))
                            send_tick($urandom_range(0, 7) != 0, $urandom_range(0, 1),
                                      $urandom_range(0, 1));
                    end
                    // overlapping presses
                    8: begin
                        hold_levels(1, 0, settle_len());
                        hold_levels(0, 0, settle_len());
                        hold_levels(0, 1, settle_len());
                    end
                    default: hold_levels(0, 1, $urandom_range(1, 10));
                endcase
            end
            // every fourth round the sender holds off until the gesture stream is empty
            if (phase % 4 == 2)
                wait_drained();
            phase++;
        end
        idle_en = 1'b0;
    endtask

    // result sink with random stall bursts
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // compare each gesture transaction with the oldest prediction
    initial begin
        t_gesture want;
        t_gesture got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_gesture'(m_axis_tdata[2:0]);
                if (gesture_q.size() == 0) begin
                    n_fail++;
                    if (n_reported < 10) begin
                        $display("unexpected gesture transaction: got %0d", got);
                        n_reported++;
                    end
                end else begin
                    want = gesture_q.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_reported < 10) begin
                            $display("gesture mismatch at result %0d: expected %0d, got %0d",
                                     n_results, want, got);
                            n_reported++;
                        end
                    end
                end
                n_results++;
            end
        end
    end

    // watchdog
    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SCAN_PERIOD;
        i_cfg_data    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_gestures();
        test_debounce_edges();
        test_scan_extremes();
        test_debounce_max();
        test_click_overflow();
        test_random();

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (n_fail == 0 && gesture_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
